// File: rtl/bpd_pkg.sv
// Package for the batch parameter deframer.
// Holds the word payload types, the result kind codes and the parser phases.
`default_nettype none

package bpd_pkg;

  typedef enum logic [1:0] {
    KIND_PARAM  = 2'd0,
    KIND_ACCEPT = 2'd1,
    KIND_REJECT = 2'd2
  } kind_e;

  typedef enum logic [5:0] {
    PH_START   = 6'b000001,
    PH_WIDTH   = 6'b000010,
    PH_LENGTH  = 6'b000100,
    PH_BATCH   = 6'b001000,
    PH_COMMAND = 6'b010000,
    PH_PARAM   = 6'b100000
  } phase_e;

  localparam logic [7:0] WIDTH_ONE  = 8'd1;
  localparam logic [7:0] WIDTH_TWO  = 8'd2;
  localparam logic [7:0] WIDTH_FOUR = 8'd4;

  localparam logic [7:0] MARKER_RESET = 8'hFF;

  typedef struct packed {
    logic [7:0] rx_byte;
  } rx_word_t;

  typedef struct packed {
    logic [7:0] setup_marker;
  } cfg_word_t;

  typedef struct packed {
    kind_e              kind;
    logic [7:0]         command;
    logic [7:0]         message_index;
    logic [7:0]         param_index;
    logic signed [15:0] param_value;
    logic               batch_end;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/bpd_stream_if.sv
// Valid/ready channel carrying one word of a packed payload type.
// Payload types come from bpd_pkg.
`default_nettype none

interface bpd_stream_if #(
  parameter type payload_t = logic [7:0]
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/bpd_parser.sv
// Setup and batch parser: all framing state plus the per-byte next-state logic.
// Uses bpd_pkg for phases, kinds, width codes and the result type.
`default_nettype none

module bpd_parser (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            step_i,
  input  wire logic [7:0]      rx_byte_i,
  input  wire logic [7:0]      setup_marker_i,
  output      logic            has_result_o,
  output      bpd_pkg::result_t result_o
);

  bpd_pkg::phase_e phase_q, phase_d;
  logic        configured_q, configured_d;
  logic [2:0]  word_bytes_q, word_bytes_d;
  logic [7:0]  params_per_msg_q, params_per_msg_d;
  logic [7:0]  msgs_per_batch_q, msgs_per_batch_d;
  logic [2:0]  pending_width_q, pending_width_d;
  logic [7:0]  pending_length_q, pending_length_d;
  logic [7:0]  msg_cnt_q, msg_cnt_d;
  logic [7:0]  param_cnt_q, param_cnt_d;
  logic [1:0]  byte_cnt_q, byte_cnt_d;
  logic [15:0] acc_q, acc_d;
  logic [7:0]  cmd_q, cmd_d;

  logic [15:0] acc_next;
  logic [2:0]  byte_cnt_inc;
  logic [7:0]  param_cnt_inc;
  logic [7:0]  msg_cnt_inc;
  logic        last_par;
  logic        last_msg;
  logic        width_ok;

  assign acc_next      = {acc_q[7:0], rx_byte_i};
  assign byte_cnt_inc  = {1'b0, byte_cnt_q} + 3'd1;
  assign param_cnt_inc = param_cnt_q + 8'd1;
  assign msg_cnt_inc   = msg_cnt_q + 8'd1;
  assign last_par      = param_cnt_inc >= params_per_msg_q;
  assign last_msg      = msg_cnt_inc >= msgs_per_batch_q;
  assign width_ok      = (rx_byte_i == bpd_pkg::WIDTH_ONE) ||
                         (rx_byte_i == bpd_pkg::WIDTH_TWO) ||
                         (rx_byte_i == bpd_pkg::WIDTH_FOUR);

  always_comb begin
    phase_d          = phase_q;
    configured_d     = configured_q;
    word_bytes_d     = word_bytes_q;
    params_per_msg_d = params_per_msg_q;
    msgs_per_batch_d = msgs_per_batch_q;
    pending_width_d  = pending_width_q;
    pending_length_d = pending_length_q;
    msg_cnt_d        = msg_cnt_q;
    param_cnt_d      = param_cnt_q;
    byte_cnt_d       = byte_cnt_q;
    acc_d            = acc_q;
    cmd_d            = cmd_q;
    has_result_o     = 1'b0;
    result_o         = '0;

    unique case (phase_q)
      bpd_pkg::PH_START: begin
        if (rx_byte_i == setup_marker_i) begin
          phase_d = bpd_pkg::PH_WIDTH;
        end else if (configured_q) begin
          msg_cnt_d   = '0;
          cmd_d       = rx_byte_i;
          param_cnt_d = '0;
          byte_cnt_d  = '0;
          acc_d       = '0;
          phase_d     = bpd_pkg::PH_PARAM;
        end
      end
      bpd_pkg::PH_WIDTH: begin
        if (width_ok) begin
          pending_width_d = rx_byte_i[2:0];
          phase_d         = bpd_pkg::PH_LENGTH;
        end else begin
          phase_d         = bpd_pkg::PH_START;
          has_result_o    = 1'b1;
          result_o.kind   = bpd_pkg::KIND_REJECT;
        end
      end
      bpd_pkg::PH_LENGTH: begin
        if (rx_byte_i != 8'd0) begin
          pending_length_d = rx_byte_i;
          phase_d          = bpd_pkg::PH_BATCH;
        end else begin
          phase_d          = bpd_pkg::PH_START;
          has_result_o     = 1'b1;
          result_o.kind    = bpd_pkg::KIND_REJECT;
        end
      end
      bpd_pkg::PH_BATCH: begin
        phase_d       = bpd_pkg::PH_START;
        has_result_o  = 1'b1;
        if (rx_byte_i != 8'd0) begin
          word_bytes_d     = pending_width_q;
          params_per_msg_d = pending_length_q;
          msgs_per_batch_d = rx_byte_i;
          configured_d     = 1'b1;
          result_o.kind    = bpd_pkg::KIND_ACCEPT;
        end else begin
          result_o.kind    = bpd_pkg::KIND_REJECT;
        end
      end
      bpd_pkg::PH_COMMAND: begin
        cmd_d       = rx_byte_i;
        param_cnt_d = '0;
        byte_cnt_d  = '0;
        acc_d       = '0;
        phase_d     = bpd_pkg::PH_PARAM;
      end
      bpd_pkg::PH_PARAM: begin
        if (byte_cnt_inc < word_bytes_q) begin
          acc_d      = acc_next;
          byte_cnt_d = byte_cnt_inc[1:0];
        end else begin
          has_result_o           = 1'b1;
          result_o.kind          = bpd_pkg::KIND_PARAM;
          result_o.command       = cmd_q;
          result_o.message_index = msg_cnt_q;
          result_o.param_index   = param_cnt_q;
          result_o.param_value   = signed'(acc_next);
          result_o.batch_end     = last_par && last_msg;
          byte_cnt_d             = '0;
          acc_d                  = '0;
          if (!last_par) begin
            param_cnt_d = param_cnt_inc;
          end else begin
            param_cnt_d = '0;
            if (last_msg) begin
              msg_cnt_d = '0;
              phase_d   = bpd_pkg::PH_START;
            end else begin
              msg_cnt_d = msg_cnt_inc;
              phase_d   = bpd_pkg::PH_COMMAND;
            end
          end
        end
      end
      default: begin
        phase_d = bpd_pkg::PH_START;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q          <= bpd_pkg::PH_START;
      configured_q     <= 1'b0;
      word_bytes_q     <= '0;
      params_per_msg_q <= '0;
      msgs_per_batch_q <= '0;
      pending_width_q  <= '0;
      pending_length_q <= '0;
      msg_cnt_q        <= '0;
      param_cnt_q      <= '0;
      byte_cnt_q       <= '0;
      acc_q            <= '0;
      cmd_q            <= '0;
    end else if (step_i) begin
      phase_q          <= phase_d;
      configured_q     <= configured_d;
      word_bytes_q     <= word_bytes_d;
      params_per_msg_q <= params_per_msg_d;
      msgs_per_batch_q <= msgs_per_batch_d;
      pending_width_q  <= pending_width_d;
      pending_length_q <= pending_length_d;
      msg_cnt_q        <= msg_cnt_d;
      param_cnt_q      <= param_cnt_d;
      byte_cnt_q       <= byte_cnt_d;
      acc_q            <= acc_d;
      cmd_q            <= cmd_d;
    end
  end

  a_batch_needs_setup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == bpd_pkg::PH_PARAM || phase_q == bpd_pkg::PH_COMMAND) |-> configured_q)
    else $error("batch parsing without an accepted setup");

  a_width_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == bpd_pkg::PH_PARAM) |->
      (word_bytes_q == 3'd1 || word_bytes_q == 3'd2 || word_bytes_q == 3'd4))
    else $error("word width out of range during batch");

  a_byte_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == bpd_pkg::PH_PARAM) |-> ({1'b0, byte_cnt_q} < word_bytes_q))
    else $error("byte count ran past word width");

  a_param_from_batch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (has_result_o && result_o.kind == bpd_pkg::KIND_PARAM) |->
      (phase_q == bpd_pkg::PH_PARAM))
    else $error("parameter word outside batch phase");

endmodule

`default_nettype wire

// File: rtl/bpd_out_reg.sv
// Result register: holds one result word until the receiver takes it.
// Uses bpd_pkg::result_t.
`default_nettype none

module bpd_out_reg (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             load_i,
  input  wire bpd_pkg::result_t data_i,
  input  wire logic             ready_i,
  output      logic             valid_o,
  output      bpd_pkg::result_t data_o,
  output      logic             free_o
);

  logic             vld_q;
  bpd_pkg::result_t data_q;

  assign free_o  = !vld_q || ready_i;
  assign valid_o = vld_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (load_i) begin
      vld_q <= 1'b1;
    end else if (ready_i) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

endmodule

`default_nettype wire

// File: rtl/batch_param_deframer.sv
// Batch parameter deframer top level: input word register, marker register,
// parser and result register. Depends on bpd_pkg, bpd_stream_if, bpd_parser, bpd_out_reg.
//
// Usage:
//   rx_i carries one received byte per word. res_o carries parameter words and
//   setup accept/reject words. cfg_i writes the setup marker; write it only
//   while the block is idle. cfg_i is always ready.
//   A byte taken on rx_i is registered in the input register, then parsed and,
//   if it yields a result, loaded into the result register and shown on res_o.
//   Throughput is one byte per cycle while res_o is not stalled, set by the
//   single parse step between the input register and the result register.
//   Reset clears both registers, returns the parser to batch start with no
//   setup and sets the marker to 0xFF. While unconfigured, bytes other than
//   the marker are dropped.
//   When the receiver stalls, the result word holds, the next byte waits unparsed in
//   the input register and rx_i.ready drops once both are full.
`default_nettype none

module batch_param_deframer (
  input wire logic   clk_i,
  input wire logic   rst_ni,
  bpd_stream_if.sink   cfg_i,
  bpd_stream_if.sink   rx_i,
  bpd_stream_if.source res_o
);

  logic             in_vld_q;
  logic [7:0]       in_byte_q;
  logic [7:0]       marker_q;
  logic             out_free;
  logic             step;
  logic             has_result;
  bpd_pkg::result_t result;

  assign cfg_i.ready = 1'b1;
  assign rx_i.ready  = !in_vld_q || out_free;
  assign step        = in_vld_q && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marker_q <= bpd_pkg::MARKER_RESET;
    end else if (cfg_i.valid) begin
      marker_q <= cfg_i.data.setup_marker;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (rx_i.ready) begin
      in_vld_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      in_byte_q <= rx_i.data.rx_byte;
    end
  end

  bpd_parser u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .rx_byte_i      (in_byte_q),
    .setup_marker_i (marker_q),
    .has_result_o   (has_result),
    .result_o       (result)
  );

  bpd_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (step && has_result),
    .data_i  (result),
    .ready_i (res_o.ready),
    .valid_o (res_o.valid),
    .data_o  (res_o.data),
    .free_o  (out_free)
  );

endmodule

`default_nettype wire

// File: bench/tb_batch_param_deframer.sv
// Self-checking testbench for batch_param_deframer: drives bytes, setups and marker writes,
// predicts every result word and checks each one as it arrives.
// Depends on bpd_pkg, bpd_stream_if and the batch_param_deframer RTL.
`default_nettype none

module tb_batch_param_deframer;

  localparam int CYCLE_LIMIT   = 150000;
  localparam int GAP_PERCENT   = 29;
  localparam int SETTLE_CYCLES = 6;

  logic clk_i;
  logic rst_ni;

  bpd_stream_if #(.payload_t(bpd_pkg::cfg_word_t)) cfg_if ();
  bpd_stream_if #(.payload_t(bpd_pkg::rx_word_t))  rx_if ();
  bpd_stream_if #(.payload_t(bpd_pkg::result_t))   res_if ();

  batch_param_deframer uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .rx_i   (rx_if),
    .res_o  (res_if)
  );

  // predicted parser state
  logic [7:0]      marker_q        = bpd_pkg::MARKER_RESET;
  bpd_pkg::phase_e ph              = bpd_pkg::PH_START;
  bit              configured_q    = 1'b0;
  logic [2:0]      word_bytes_q    = '0;
  logic [7:0]      params_per_msg  = '0;
  logic [7:0]      msgs_per_batch  = '0;
  logic [2:0]      pend_width_q    = '0;
  logic [7:0]      pend_len_q      = '0;
  logic [7:0]      msg_cnt_q       = '0;
  logic [7:0]      param_cnt_q     = '0;
  logic [1:0]      byte_cnt_q      = '0;
  logic [15:0]     acc_q           = '0;
  logic [7:0]      cmd_q           = '0;

  bpd_pkg::result_t frames_due[$];
  int      mismatches = 0;
  int      bytes_sent = 0;
  int      cycles     = 0;
  bit      steady     = 1'b0;

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    res_if.ready <= steady || ($urandom_range(99) >= GAP_PERCENT);
  end

  function automatic void open_message(input logic [7:0] b);
    cmd_q       = b;
    param_cnt_q = '0;
    byte_cnt_q  = '0;
    acc_q       = '0;
    ph          = bpd_pkg::PH_PARAM;
  endfunction

  function automatic void deframe_byte(input logic [7:0] b);
    bpd_pkg::result_t r;
    bit      emit_r;
    logic    last_par;
    logic    last_msg;
    r      = '0;
    emit_r = 1'b0;
    case (ph)
      bpd_pkg::PH_START: begin
        if (b == marker_q) begin
          ph = bpd_pkg::PH_WIDTH;
        end else if (configured_q) begin
          msg_cnt_q = '0;
          open_message(b);
        end
      end
      bpd_pkg::PH_WIDTH: begin
        if (b == bpd_pkg::WIDTH_ONE || b == bpd_pkg::WIDTH_TWO ||
            b == bpd_pkg::WIDTH_FOUR) begin
          pend_width_q = b[2:0];
          ph = bpd_pkg::PH_LENGTH;
        end else begin
          r.kind = bpd_pkg::KIND_REJECT;
          emit_r = 1'b1;
          ph = bpd_pkg::PH_START;
        end
      end
      bpd_pkg::PH_LENGTH: begin
        if (b == 8'd0) begin
          r.kind = bpd_pkg::KIND_REJECT;
          emit_r = 1'b1;
          ph = bpd_pkg::PH_START;
        end else begin
          pend_len_q = b;
          ph = bpd_pkg::PH_BATCH;
        end
      end
      bpd_pkg::PH_BATCH: begin
        r.kind = (b == 8'd0) ? bpd_pkg::KIND_REJECT : bpd_pkg::KIND_ACCEPT;
        emit_r = 1'b1;
        if (b != 8'd0) begin
          word_bytes_q   = pend_width_q;
          params_per_msg = pend_len_q;
          msgs_per_batch = b;
          configured_q   = 1'b1;
        end
        ph = bpd_pkg::PH_START;
      end
      bpd_pkg::PH_COMMAND: open_message(b);
      bpd_pkg::PH_PARAM: begin
        acc_q = {acc_q[7:0], b};
        if (int'(byte_cnt_q) + 1 < int'(word_bytes_q)) begin
          byte_cnt_q = byte_cnt_q + 2'd1;
        end else begin
          last_par        = (param_cnt_q + 8'd1) >= params_per_msg;
          last_msg        = (msg_cnt_q + 8'd1) >= msgs_per_batch;
          r.kind          = bpd_pkg::KIND_PARAM;
          r.command       = cmd_q;
          r.message_index = msg_cnt_q;
          r.param_index   = param_cnt_q;
          r.param_value   = acc_q;
          r.batch_end     = last_par && last_msg;
          emit_r          = 1'b1;
          byte_cnt_q      = '0;
          acc_q           = '0;
          if (!last_par) begin
            param_cnt_q = param_cnt_q + 8'd1;
          end else begin
            param_cnt_q = '0;
            if (last_msg) begin
              msg_cnt_q = '0;
              ph = bpd_pkg::PH_START;
            end else begin
              msg_cnt_q = msg_cnt_q + 8'd1;
              ph = bpd_pkg::PH_COMMAND;
            end
          end
        end
      end
      default: ph = bpd_pkg::PH_START;
    endcase
    if (emit_r) frames_due.push_back(r);
  endfunction

  task automatic compare_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : check_results
    bpd_pkg::result_t exp_r;
    bpd_pkg::result_t got_r;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got_r = res_if.data;
      if (frames_due.size() == 0) begin
        $display("%0t: unexpected word, expected none, got %h", $time, got_r);
        mismatches++;
      end else begin
        exp_r = frames_due.pop_front();
        compare_field("kind", int'(exp_r.kind), int'(got_r.kind));
        compare_field("command", exp_r.command, got_r.command);
        compare_field("message_index", exp_r.message_index, got_r.message_index);
        compare_field("param_index", exp_r.param_index, got_r.param_index);
        compare_field("param_value", int'(exp_r.param_value), int'(got_r.param_value));
        compare_field("batch_end", exp_r.batch_end, got_r.batch_end);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while (!steady && $urandom_range(99) < GAP_PERCENT) begin
      rx_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    rx_if.valid <= 1'b1;
    rx_if.data  <= b;
    do @(posedge clk_i); while (!rx_if.ready);
    deframe_byte(b);
    bytes_sent++;
  endtask

  task automatic send_seq(input logic [7:0] seq[$]);
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  task automatic wait_for_quiet();
    rx_if.valid <= 1'b0;
    @(posedge clk_i);
    while (frames_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_marker(input logic [7:0] m);
    wait_for_quiet();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= m;
    do @(posedge clk_i); while (!cfg_if.ready);
    marker_q = m;
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic [7:0] pick_value();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_random_setup();
    logic [7:0] w;
    logic [7:0] len;
    logic [7:0] msgs;
    case ($urandom_range(2))
      0: w = bpd_pkg::WIDTH_ONE;
      1: w = bpd_pkg::WIDTH_TWO;
      default: w = bpd_pkg::WIDTH_FOUR;
    endcase
    if ($urandom_range(9) == 0) w = 8'($urandom_range(255));
    len  = 8'($urandom_range(1, 4));
    msgs = 8'($urandom_range(1, 4));
    if ($urandom_range(29) == 0) begin
      w = bpd_pkg::WIDTH_ONE;
      if ($urandom_range(1) == 1) begin
        len  = 8'd255;
        msgs = 8'd1;
      end else begin
        msgs = 8'd255;
        len  = 8'd1;
      end
    end
    if ($urandom_range(9) == 0) len = 8'd0;
    else if ($urandom_range(9) == 0) msgs = 8'd0;
    send_byte(marker_q);
    send_byte(w);
    if (ph == bpd_pkg::PH_LENGTH) send_byte(len);
    if (ph == bpd_pkg::PH_BATCH) send_byte(msgs);
  endtask

  task automatic send_random_batch();
    int         n_msgs;
    int         n_bytes;
    logic [7:0] c;
    n_msgs  = msgs_per_batch;
    n_bytes = int'(params_per_msg) * int'(word_bytes_q);
    for (int i = 0; i < n_msgs; i++) begin
      c = 8'($urandom_range(255));
      if (i == 0 && c == marker_q) c = ~c;
      send_byte(c);
      for (int j = 0; j < n_bytes; j++) send_byte(pick_value());
    end
  endtask

  // drop setups with a zero byte, complete batches with data
  task automatic finish_unit();
    while (ph != bpd_pkg::PH_START) begin
      if (ph == bpd_pkg::PH_WIDTH || ph == bpd_pkg::PH_LENGTH || ph == bpd_pkg::PH_BATCH)
        send_byte(8'h00);
      else send_byte(8'($urandom_range(255)));
    end
  endtask

  task automatic test_unconfigured_drop();
    write_marker(bpd_pkg::MARKER_RESET);
    send_seq('{8'h12, 8'hFF, 8'h03});
  endtask

  task automatic test_setup_handling();
    send_seq('{8'hFF, bpd_pkg::WIDTH_TWO, 8'h02, 8'h02});
    send_seq('{8'hFF, bpd_pkg::WIDTH_ONE, 8'h00});
  endtask

  task automatic test_batch_parsing();
    send_seq('{8'h00, 8'h7F, 8'hFF, 8'h80, 8'h00});
    send_seq('{8'hFF, 8'h00, 8'h01, 8'hFF, 8'hFF});
  endtask

  task automatic test_wide_words();
    send_seq('{8'hFF, bpd_pkg::WIDTH_FOUR, 8'h01, 8'h01});
    send_seq('{8'h5A, 8'h12, 8'h34, 8'h80, 8'h00});
    send_seq('{8'hFF, bpd_pkg::WIDTH_ONE, 8'h01, 8'h00});
  endtask

  task automatic test_random_stream(input logic [7:0] m, input int n, input bit no_gaps);
    int stop_at;
    int sel;
    write_marker(m);
    steady  = no_gaps;
    stop_at = bytes_sent + n;
    while (bytes_sent < stop_at) begin
      sel = $urandom_range(99);
      if (!configured_q || sel < 15) begin
        send_random_setup();
      end else if (sel < 22) begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)));
        finish_unit();
      end else begin
        send_random_batch();
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    rst_ni       = 1'b0;
    rx_if.valid  = 1'b0;
    rx_if.data   = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    res_if.ready = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_unconfigured_drop();
    test_setup_handling();
    test_batch_parsing();
    test_wide_words();
    test_random_stream(8'h00, 390, 1'b0);
    test_random_stream(8'($urandom_range(1, 254)), 390, 1'b0);
    test_random_stream(8'hFF, 390, 1'b1);
    test_random_stream(8'($urandom_range(1, 254)), 390, 1'b0);

    wait_for_quiet();
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
rtl/bpd_pkg.sv
rtl/bpd_stream_if.sv
rtl/bpd_parser.sv
rtl/bpd_out_reg.sv
rtl/batch_param_deframer.sv
bench/tb_batch_param_deframer.sv
